// ----- hdl/fprs_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the packet statistics engine.
package fprs_pkg;

  localparam int unsigned PORTS  = 2;
  localparam int unsigned QUEUES = 8;
  localparam int unsigned FLOWS  = 1024;

  localparam int unsigned SLOTS    = PORTS * 2;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned QC_DEPTH = SLOTS * QUEUES;
  localparam int unsigned QC_AW    = $clog2(QC_DEPTH);
  localparam int unsigned FC_DEPTH = 2 * QUEUES * FLOWS;
  localparam int unsigned FC_AW    = $clog2(FC_DEPTH);
  localparam int unsigned FOFF_W   = $clog2(FLOWS);
  localparam int unsigned QCNT_W   = $clog2(QUEUES + 1);

  localparam int unsigned CNT_W      = 64;
  localparam int unsigned HALF_W     = CNT_W / 2;
  localparam int unsigned IP_W       = 32;
  localparam int unsigned FPB_W      = 14;
  localparam int unsigned QUSED_W    = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam int unsigned FRAME_OVERHEAD_BYTES = 24;
  localparam int unsigned FBYTES_W   = FPB_W + 1;
  localparam int unsigned FBITS_W    = FBYTES_W + 3;
  localparam int unsigned PROD_W     = HALF_W + FBITS_W;
  localparam int unsigned ONE_MILLION = 1000000;

  // Division by one million is a shift by six followed by a division by 15625, done one
  // 16-bit quotient digit at a time with a reciprocal that is exact for every partial dividend.
  localparam int unsigned     DIGIT_W      = 16;
  localparam int unsigned     DIV_DIGITS   = CNT_W / DIGIT_W;
  localparam int unsigned     DIV_SHIFT    = 6;
  localparam int unsigned     DIV_BASE     = ONE_MILLION >> DIV_SHIFT;
  localparam int unsigned     REM_W        = $clog2(DIV_BASE);
  localparam int unsigned     TRIAL_W      = REM_W + DIGIT_W;
  localparam int unsigned     RECIP_SHIFT  = TRIAL_W + REM_W;
  localparam longint unsigned RECIP        = ((64'd1 << RECIP_SHIFT) + DIV_BASE - 1) / DIV_BASE;
  localparam int unsigned     RECIP_W      = $clog2(RECIP);
  localparam int unsigned     RECIP_PROD_W = TRIAL_W + RECIP_W;
  localparam int unsigned     DIVCNT_W     = $clog2(2 * DIV_DIGITS);

  localparam logic [1:0] KIND_COUNT  = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RX_QUEUES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TX_QUEUES   = 3'd4;

  typedef struct packed {
    logic load;
    logic clear_wr;
    logic count_wr;
    logic emit;
    logic sum_step;
    logic delta_upd;
    logic mul_stage;
    logic mul_add;
    logic div_step;
    logic conv_store;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       clear_last;
    logic       count_ok;
    logic       port_ok;
    logic       sum_done;
    logic       div_last;
    logic       conv_total;
  } dp_status_t;

endpackage

// ----- hdl/fprs_ctrl.sv -----
// Sequencing state machine of the packet statistics engine.
module fprs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  fprs_pkg::dp_status_t status_i,
  output fprs_pkg::ctrl_cmd_t  cmd_o,
  output logic                 busy,
  output logic                 result_valid_o
);
  import fprs_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FIRST = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_DELTA = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_ADD   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_STORE = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_FIRST;
        end
      end
      S_FIRST: begin
        case (status_i.kind)
          KIND_COUNT: begin
            cmd_o.count_wr = status_i.count_ok;
            cmd_o.emit     = 1'b1;
            state_d        = S_IDLE;
          end
          KIND_SAMPLE: begin
            if (status_i.port_ok) begin
              state_d = S_SUM;
            end else begin
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
            end
          end
          default: begin
            cmd_o.emit = 1'b1;
            state_d    = S_IDLE;
          end
        endcase
      end
      S_SUM: begin
        if (status_i.sum_done) state_d = S_DELTA;
        else cmd_o.sum_step = 1'b1;
      end
      S_DELTA: begin
        cmd_o.delta_upd = 1'b1;
        state_d         = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_stage = 1'b1;
        state_d         = S_ADD;
      end
      S_ADD: begin
        cmd_o.mul_add = 1'b1;
        state_d       = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_STORE;
      end
      S_STORE: begin
        cmd_o.conv_store = 1'b1;
        state_d          = status_i.conv_total ? S_EMIT : S_MUL;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= cmd_o.emit;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;

endmodule

// ----- hdl/fprs_datapath.sv -----
// Counters, flow memory, sample accumulation and megabit conversion of the statistics engine.
module fprs_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fprs_pkg::ctrl_cmd_t              cmd_i,
  output fprs_pkg::dp_status_t             status_o,
  input  logic                             cfg_we_i,
  input  logic [fprs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fprs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [1:0]                       kind_i,
  input  logic [fprs_pkg::IP_W-1:0]        ip_address_i,
  input  logic                             port_index_i,
  input  logic [2:0]                       queue_index_i,
  input  logic                             is_transmit_i,
  output logic                             accepted_o,
  output logic [fprs_pkg::CNT_W-1:0]       packets_per_sec_o,
  output logic [fprs_pkg::CNT_W-1:0]       max_packets_per_sec_o,
  output logic [fprs_pkg::CNT_W-1:0]       mbits_per_sec_o,
  output logic [fprs_pkg::CNT_W-1:0]       total_packets_o,
  output logic [fprs_pkg::CNT_W-1:0]       total_mbits_o,
  output logic [fprs_pkg::CNT_W-1:0]       flow_count_o
);
  import fprs_pkg::*;

  // Configuration registers.
  logic [IP_W-1:0]    range_start_q, range_end_q;
  logic [FPB_W-1:0]   frame_bytes_q;
  logic [QUSED_W-1:0] rx_used_q, tx_used_q;

  // Item registers.
  logic [1:0]       kind_q;
  logic [IP_W-1:0]  ip_q;
  logic             port_q;
  logic [2:0]       queue_q;
  logic             dir_q;
  logic [FC_AW-1:0] fc_addr_q;

  // Counter storage.
  logic [CNT_W-1:0] qc_q [QC_DEPTH];
  logic [CNT_W-1:0] prev_q [SLOTS];
  logic [CNT_W-1:0] peak_q [SLOTS];
  logic [CNT_W-1:0] fc_mem [FC_DEPTH];
  logic [CNT_W-1:0] fc_rd_q;
  logic [FC_AW-1:0] clr_addr_q;

  // Sample and conversion registers.
  logic [QCNT_W-1:0]   qcnt_q;
  logic [CNT_W-1:0]    total_q, delta_q, peak_out_q, mbps_q;
  logic                conv_sel_q;
  logic [PROD_W-1:0]   plo_q;
  logic [HALF_W-1:0]   phi_q;
  logic [CNT_W-1:0]    dvd_q;
  logic [REM_W-1:0]    rem_q;
  logic [DIGIT_W-1:0]  qd_q;
  logic [DIVCNT_W-1:0] divcnt_q;

  // Result registers.
  logic             acc_q;
  logic [CNT_W-1:0] pps_q, maxpps_q, mbps_out_q, tot_q, totmb_q, flow_q;

  logic [FOFF_W-1:0]  off_lo;
  logic [FC_AW-1:0]   rd_addr;
  logic [IP_W-1:0]    ip_diff;
  logic               range_ok, port_ok, queue_ok, count_ok;
  logic [SLOT_W-1:0]  slot;
  logic [QC_AW-1:0]   cnt_idx, sum_idx, qc_idx;
  logic [CNT_W-1:0]   qc_rd;
  logic [QUSED_W-1:0] used_raw;
  logic [QCNT_W-1:0]  used;
  logic [CNT_W-1:0]   delta_d;
  logic [CNT_W-1:0]   conv_op;
  logic [FBYTES_W-1:0] frame_bytes;
  logic [FBITS_W-1:0] frame_bits;
  logic [PROD_W-1:0]  plo_d, phi_full;
  logic [TRIAL_W-1:0] trial;
  logic [RECIP_PROD_W-1:0] recip_prod;
  logic [TRIAL_W-1:0] qd_mul;
  logic               fc_we;
  logic [FC_AW-1:0]   fc_wa;
  logic [CNT_W-1:0]   fc_wd;

  assign off_lo  = ip_address_i[FOFF_W-1:0] - range_start_q[FOFF_W-1:0];
  assign rd_addr = FC_AW'((32'(is_transmit_i) * QUEUES + 32'(queue_index_i)) * FLOWS)
                   + FC_AW'(off_lo);

  assign ip_diff  = ip_q - range_start_q;
  assign range_ok = (ip_q >= range_start_q) && (ip_q <= range_end_q) && (ip_diff < IP_W'(FLOWS));
  assign port_ok  = (32'(port_q) < PORTS);
  assign queue_ok = (32'(queue_q) < QUEUES);
  assign count_ok = (ip_q != '0) && range_ok && port_ok && queue_ok;

  assign slot    = SLOT_W'(32'(port_q) * 2 + 32'(dir_q));
  assign cnt_idx = QC_AW'(32'(slot) * QUEUES + 32'(queue_q));
  assign sum_idx = QC_AW'(32'(slot) * QUEUES + 32'(qcnt_q));
  assign qc_idx  = cmd_i.sum_step ? sum_idx : cnt_idx;
  assign qc_rd   = qc_q[qc_idx];

  assign used_raw = dir_q ? tx_used_q : rx_used_q;
  assign used     = (32'(used_raw) > QUEUES) ? QCNT_W'(QUEUES) : QCNT_W'(used_raw);
  assign delta_d  = total_q - prev_q[slot];

  assign frame_bytes = FBYTES_W'(frame_bytes_q) + FBYTES_W'(FRAME_OVERHEAD_BYTES);
  assign frame_bits  = {frame_bytes, 3'b000};
  assign conv_op     = conv_sel_q ? total_q : delta_q;
  assign plo_d       = PROD_W'(conv_op[HALF_W-1:0]) * PROD_W'(frame_bits);
  assign phi_full    = PROD_W'(conv_op[CNT_W-1:HALF_W]) * PROD_W'(frame_bits);

  assign trial      = {rem_q, dvd_q[CNT_W-1 -: DIGIT_W]};
  assign recip_prod = RECIP_PROD_W'(trial) * RECIP_PROD_W'(RECIP);
  assign qd_mul     = TRIAL_W'(qd_q) * TRIAL_W'(DIV_BASE);

  assign fc_we = cmd_i.clear_wr || cmd_i.count_wr;
  assign fc_wa = cmd_i.clear_wr ? clr_addr_q : fc_addr_q;
  assign fc_wd = cmd_i.clear_wr ? '0 : fc_rd_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (fc_we) fc_mem[fc_wa] <= fc_wd;
    if (cmd_i.load) fc_rd_q <= fc_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_start_q <= '0;
      range_end_q   <= '0;
      frame_bytes_q <= '0;
      rx_used_q     <= '0;
      tx_used_q     <= '0;
      clr_addr_q    <= '0;
      for (int i = 0; i < QC_DEPTH; i++) qc_q[i] <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        prev_q[s] <= '0;
        peak_q[s] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_RANGE_START: range_start_q <= cfg_wdata_i;
          REG_RANGE_END:   range_end_q   <= cfg_wdata_i;
          REG_FRAME_BYTES: frame_bytes_q <= cfg_wdata_i[FPB_W-1:0];
          REG_RX_QUEUES:   rx_used_q     <= cfg_wdata_i[QUSED_W-1:0];
          REG_TX_QUEUES:   tx_used_q     <= cfg_wdata_i[QUSED_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clear_wr) clr_addr_q <= clr_addr_q + 1'b1;
      if (cmd_i.count_wr) qc_q[cnt_idx] <= qc_rd + 1'b1;
      if (cmd_i.delta_upd) begin
        prev_q[slot] <= total_q;
        if (peak_q[slot] < delta_d) peak_q[slot] <= delta_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q    <= kind_i;
      ip_q      <= ip_address_i;
      port_q    <= port_index_i;
      queue_q   <= queue_index_i;
      dir_q     <= is_transmit_i;
      fc_addr_q <= rd_addr;
      total_q   <= '0;
      qcnt_q    <= '0;
    end
    if (cmd_i.sum_step) begin
      total_q <= total_q + qc_rd;
      qcnt_q  <= qcnt_q + 1'b1;
    end
    if (cmd_i.delta_upd) begin
      delta_q    <= delta_d;
      peak_out_q <= (peak_q[slot] < delta_d) ? delta_d : peak_q[slot];
      conv_sel_q <= 1'b0;
    end
    if (cmd_i.mul_stage) begin
      plo_q <= plo_d;
      phi_q <= phi_full[HALF_W-1:0];
    end
    if (cmd_i.mul_add) begin
      dvd_q    <= (CNT_W'(plo_q) + {phi_q, {HALF_W{1'b0}}}) >> DIV_SHIFT;
      rem_q    <= '0;
      divcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      // Even steps estimate the next quotient digit, odd steps form the remainder and shift.
      if (!divcnt_q[0]) begin
        qd_q <= recip_prod[RECIP_SHIFT +: DIGIT_W];
      end else begin
        rem_q <= REM_W'(trial - qd_mul);
        dvd_q <= {dvd_q[CNT_W-DIGIT_W-1:0], qd_q};
      end
      divcnt_q <= divcnt_q + 1'b1;
    end
    if (cmd_i.conv_store && !conv_sel_q) begin
      mbps_q     <= dvd_q;
      conv_sel_q <= 1'b1;
    end
    if (cmd_i.emit) begin
      acc_q      <= 1'b0;
      pps_q      <= '0;
      maxpps_q   <= '0;
      mbps_out_q <= '0;
      tot_q      <= '0;
      totmb_q    <= '0;
      flow_q     <= '0;
      case (kind_q)
        KIND_COUNT: acc_q <= count_ok;
        KIND_SAMPLE: begin
          if (port_ok) begin
            pps_q      <= delta_q;
            maxpps_q   <= peak_out_q;
            mbps_out_q <= mbps_q;
            tot_q      <= total_q;
            totmb_q    <= dvd_q;
          end
        end
        KIND_READ: flow_q <= (queue_ok && range_ok) ? fc_rd_q : '0;
        default: ;
      endcase
    end
  end

  assign status_o.kind       = kind_q;
  assign status_o.clear_last = (clr_addr_q == FC_AW'(FC_DEPTH - 1));
  assign status_o.count_ok   = count_ok;
  assign status_o.port_ok    = port_ok;
  assign status_o.sum_done   = (qcnt_q == used);
  assign status_o.div_last   = (divcnt_q == DIVCNT_W'(2 * DIV_DIGITS - 1));
  assign status_o.conv_total = conv_sel_q;

  assign accepted_o            = acc_q;
  assign packets_per_sec_o     = pps_q;
  assign max_packets_per_sec_o = maxpps_q;
  assign mbits_per_sec_o       = mbps_out_q;
  assign total_packets_o       = tot_q;
  assign total_mbits_o         = totmb_q;
  assign flow_count_o          = flow_q;

endmodule

// ----- hdl/flow_packet_rate_stats.sv -----
// Top level of the packet statistics engine: controller, datapath and checks.
// After reset the block sweeps the flow counter memory to zero, one entry per cycle, and holds
// busy high until all 16384 entries are zero; configuration writes are taken during the sweep.
// A count or read beat is accepted when start is high and busy is low. Its result is
// registered onto result_valid_o after the S_FIRST state, in the same cycle in which the
// next beat can be accepted, so a new count or read is taken only once the last is done.
// A sample beat walks the in-use queue counters one per cycle and then runs two divisions
// by one million, each as four 16-bit quotient digits found by reciprocal multiplication,
// each digit in an estimate step and then a remainder step. Results cannot be stalled: each
// one is valid for one cycle only and the fields hold their values until the next result.
module flow_packet_rate_stats (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cfg_we_i,
  input  logic [fprs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fprs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [1:0]                       kind_i,
  input  logic [fprs_pkg::IP_W-1:0]        ip_address_i,
  input  logic                             port_index_i,
  input  logic [2:0]                       queue_index_i,
  input  logic                             is_transmit_i,
  output logic                             result_valid_o,
  output logic                             accepted_o,
  output logic [fprs_pkg::CNT_W-1:0]       packets_per_sec_o,
  output logic [fprs_pkg::CNT_W-1:0]       max_packets_per_sec_o,
  output logic [fprs_pkg::CNT_W-1:0]       mbits_per_sec_o,
  output logic [fprs_pkg::CNT_W-1:0]       total_packets_o,
  output logic [fprs_pkg::CNT_W-1:0]       total_mbits_o,
  output logic [fprs_pkg::CNT_W-1:0]       flow_count_o
);
  import fprs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  fprs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  fprs_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .status_o              (status),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .kind_i                (kind_i),
    .ip_address_i          (ip_address_i),
    .port_index_i          (port_index_i),
    .queue_index_i         (queue_index_i),
    .is_transmit_i         (is_transmit_i),
    .accepted_o            (accepted_o),
    .packets_per_sec_o     (packets_per_sec_o),
    .max_packets_per_sec_o (max_packets_per_sec_o),
    .mbits_per_sec_o       (mbits_per_sec_o),
    .total_packets_o       (total_packets_o),
    .total_mbits_o         (total_mbits_o),
    .flow_count_o          (flow_count_o)
  );

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Accepted beat did not make the block busy.");

  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("Result strobe lasted more than one cycle.");

  a_strobe_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("Result strobe while the block is still busy.");

endmodule

// ----- tb/sv/fprs_stats_checker.sv -----
// Checker for the packet statistics engine: predicts every result beat and compares it.
module fprs_stats_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic                            cfg_we_i,
  input  logic [fprs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fprs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [1:0]                      kind_i,
  input  logic [fprs_pkg::IP_W-1:0]       ip_address_i,
  input  logic                            port_index_i,
  input  logic [2:0]                      queue_index_i,
  input  logic                            is_transmit_i,
  input  logic                            result_valid_i,
  input  logic                            accepted_i,
  input  logic [fprs_pkg::CNT_W-1:0]      packets_per_sec_i,
  input  logic [fprs_pkg::CNT_W-1:0]      max_packets_per_sec_i,
  input  logic [fprs_pkg::CNT_W-1:0]      mbits_per_sec_i,
  input  logic [fprs_pkg::CNT_W-1:0]      total_packets_i,
  input  logic [fprs_pkg::CNT_W-1:0]      total_mbits_i,
  input  logic [fprs_pkg::CNT_W-1:0]      flow_count_i,
  output int unsigned                     mismatches_o,
  output int unsigned                     owed_o
);
  import fprs_pkg::*;

  localparam int unsigned BITS_PER_BYTE = 8;

  typedef struct {
    logic             accepted;
    logic [CNT_W-1:0] pps;
    logic [CNT_W-1:0] peak;
    logic [CNT_W-1:0] mbps;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] total_mbits;
    logic [CNT_W-1:0] flow;
  } stats_beat_t;

  logic [IP_W-1:0]    lo_ip;
  logic [IP_W-1:0]    hi_ip;
  logic [FPB_W-1:0]   payload_bytes;
  logic [QUSED_W-1:0] rx_used;
  logic [QUSED_W-1:0] tx_used;

  logic [CNT_W-1:0] queue_cnt [QC_DEPTH];
  logic [CNT_W-1:0] flow_cnt [FC_DEPTH];
  logic [CNT_W-1:0] last_total [SLOTS];
  logic [CNT_W-1:0] peak_rate [SLOTS];

  stats_beat_t owed_stats [$];

  function automatic logic lookup_flow(input logic [IP_W-1:0] ip, output logic [FOFF_W-1:0] off);
    logic [IP_W-1:0] gap;
    off = '0;
    if (ip < lo_ip || ip > hi_ip) return 1'b0;
    gap = ip - lo_ip;
    if (gap >= FLOWS) return 1'b0;
    off = gap[FOFF_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] to_mbits(input logic [CNT_W-1:0] pkts);
    logic [CNT_W-1:0] frame_bits;
    logic [CNT_W-1:0] prod;
    frame_bits = (64'(FRAME_OVERHEAD_BYTES) + 64'(payload_bytes)) * 64'(BITS_PER_BYTE);
    prod = pkts * frame_bits;
    return prod / 64'(ONE_MILLION);
  endfunction

  function automatic stats_beat_t predict_stats(input logic [1:0] kind, input logic [IP_W-1:0] ip,
                                                input logic port, input logic [2:0] queue,
                                                input logic dir);
    stats_beat_t      r;
    logic [FOFF_W-1:0] off;
    int unsigned      slot;
    int unsigned      used;
    logic [CNT_W-1:0] sum;
    logic [CNT_W-1:0] delta;
    r = '{default: '0};
    off = '0;
    sum = '0;
    slot = 2 * int'(port) + int'(dir);
    case (kind)
      KIND_COUNT: begin
        if (ip != '0 && port < PORTS && queue < QUEUES && lookup_flow(ip, off)) begin
          queue_cnt[slot * QUEUES + queue] += 1;
          flow_cnt[(int'(dir) * QUEUES + queue) * FLOWS + off] += 1;
          r.accepted = 1'b1;
        end
      end
      KIND_SAMPLE: begin
        if (port < PORTS) begin
          used = dir ? tx_used : rx_used;
          if (used > QUEUES) used = QUEUES;
          for (int unsigned q = 0; q < used; q++) sum += queue_cnt[slot * QUEUES + q];
          delta = sum - last_total[slot];
          if (peak_rate[slot] < delta) peak_rate[slot] = delta;
          last_total[slot] = sum;
          r.pps = delta;
          r.peak = peak_rate[slot];
          r.mbps = to_mbits(delta);
          r.total = sum;
          r.total_mbits = to_mbits(sum);
        end
      end
      KIND_READ: begin
        if (queue < QUEUES && lookup_flow(ip, off)) begin
          r.flow = flow_cnt[(int'(dir) * QUEUES + queue) * FLOWS + off];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      mismatches_o++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stats_beat_t want;
    if (!rst_ni) begin
      lo_ip = '0;
      hi_ip = '0;
      payload_bytes = '0;
      rx_used = '0;
      tx_used = '0;
      foreach (queue_cnt[i]) queue_cnt[i] = '0;
      foreach (flow_cnt[i]) flow_cnt[i] = '0;
      foreach (last_total[i]) last_total[i] = '0;
      foreach (peak_rate[i]) peak_rate[i] = '0;
      owed_stats.delete();
      mismatches_o = 0;
      owed_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_RANGE_START: lo_ip = cfg_wdata_i[IP_W-1:0];
          REG_RANGE_END:   hi_ip = cfg_wdata_i[IP_W-1:0];
          REG_FRAME_BYTES: payload_bytes = cfg_wdata_i[FPB_W-1:0];
          REG_RX_QUEUES:   rx_used = cfg_wdata_i[QUSED_W-1:0];
          REG_TX_QUEUES:   tx_used = cfg_wdata_i[QUSED_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        owed_stats.push_back(predict_stats(kind_i, ip_address_i, port_index_i, queue_index_i,
                                           is_transmit_i));
      end
      if (result_valid_i) begin
        if (owed_stats.size() == 0) begin
          mismatches_o++;
          $error("Result beat arrived with no prediction outstanding.");
        end else begin
          want = owed_stats.pop_front();
          check_field("accepted", 64'(want.accepted), 64'(accepted_i));
          check_field("packets_per_sec", want.pps, packets_per_sec_i);
          check_field("max_packets_per_sec", want.peak, max_packets_per_sec_i);
          check_field("mbits_per_sec", want.mbps, mbits_per_sec_i);
          check_field("total_packets", want.total, total_packets_i);
          check_field("total_mbits", want.total_mbits, total_mbits_i);
          check_field("flow_count", want.flow, flow_count_i);
        end
      end
      owed_o <= owed_stats.size();
    end
  end

endmodule

// ----- tb/sv/flow_packet_rate_stats_tb.sv -----
// Top of the packet statistics engine testbench: clock, reset, stimulus and verdict.
module flow_packet_rate_stats_tb;
  import fprs_pkg::*;

  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned TAIL        = 160;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic [1:0]            kind_i;
  logic [IP_W-1:0]       ip_address_i;
  logic                  port_index_i;
  logic [2:0]            queue_index_i;
  logic                  is_transmit_i;
  logic                  result_valid_o;
  logic                  accepted_o;
  logic [CNT_W-1:0]      packets_per_sec_o;
  logic [CNT_W-1:0]      max_packets_per_sec_o;
  logic [CNT_W-1:0]      mbits_per_sec_o;
  logic [CNT_W-1:0]      total_packets_o;
  logic [CNT_W-1:0]      total_mbits_o;
  logic [CNT_W-1:0]      flow_count_o;

  int unsigned     mismatches;
  int unsigned     owed;
  int unsigned     cycle_count = 0;
  int unsigned     settings_used;
  int unsigned     drains;
  int unsigned     beats_by_kind [4];
  logic [IP_W-1:0] cur_start;
  logic [IP_W-1:0] cur_end;

  flow_packet_rate_stats dut (.*);

  fprs_stats_checker checker_i (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start_i               (start),
    .busy_i                (busy),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .kind_i                (kind_i),
    .ip_address_i          (ip_address_i),
    .port_index_i          (port_index_i),
    .queue_index_i         (queue_index_i),
    .is_transmit_i         (is_transmit_i),
    .result_valid_i        (result_valid_o),
    .accepted_i            (accepted_o),
    .packets_per_sec_i     (packets_per_sec_o),
    .max_packets_per_sec_i (max_packets_per_sec_o),
    .mbits_per_sec_i       (mbits_per_sec_o),
    .total_packets_i       (total_packets_o),
    .total_mbits_i         (total_mbits_o),
    .flow_count_i          (flow_count_o),
    .mismatches_o          (mismatches),
    .owed_o                (owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_beat(input logic [1:0] kind, input logic [IP_W-1:0] ip, input logic port,
                           input logic [2:0] queue, input logic dir);
    start <= 1'b1;
    kind_i <= kind;
    ip_address_i <= ip;
    port_index_i <= port;
    queue_index_i <= queue;
    is_transmit_i <= dir;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    beats_by_kind[kind]++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (owed != 0) @(posedge clk_i);
    drains++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [IP_W-1:0] lo, input logic [IP_W-1:0] hi,
                           input logic [FPB_W-1:0] fpb, input logic [QUSED_W-1:0] rxq,
                           input logic [QUSED_W-1:0] txq);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    write_reg(REG_RANGE_START, lo);
    write_reg(REG_RANGE_END, hi);
    write_reg(REG_FRAME_BYTES, CFG_DATA_W'(fpb));
    write_reg(REG_RX_QUEUES, CFG_DATA_W'(rxq));
    write_reg(REG_TX_QUEUES, CFG_DATA_W'(txq));
    cfg_we_i <= 1'b0;
    cur_start = lo;
    cur_end = hi;
    settings_used++;
  endtask

  task automatic configure_random();
    logic [IP_W-1:0] lo;
    logic [IP_W-1:0] hi;
    int unsigned     width;
    lo = $urandom;
    width = $urandom_range(0, 2047);
    hi = (lo > 32'hFFFF_FFFF - width) ? 32'hFFFF_FFFF : lo + width;
    configure(lo, hi, FPB_W'($urandom_range(0, 16383)), QUSED_W'($urandom_range(0, 15)),
              QUSED_W'($urandom_range(0, 15)));
  endtask

  function automatic logic [IP_W-1:0] pick_ip();
    int unsigned r;
    int unsigned span;
    int unsigned offset;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 15) return $urandom;
    if (r < 25) begin
      case ($urandom_range(0, 3))
        0: return cur_start - 1;
        1: return cur_end + 1;
        2: return cur_start + FLOWS;
        default: return cur_start + FLOWS - 1;
      endcase
    end
    if (cur_start > cur_end) return $urandom;
    span = cur_end - cur_start;
    if (span > FLOWS + 63) span = FLOWS + 63;
    if (r < 60) offset = $urandom_range(0, (span < 15) ? span : 15);
    else offset = $urandom_range(0, span);
    return cur_start + offset;
  endfunction

  task automatic run_random(input int unsigned n_items, input int unsigned idle_pct);
    int unsigned r;
    logic [1:0]  kind;
    for (int unsigned i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      if ($urandom_range(0, 199) == 0) drain();
      r = $urandom_range(0, 99);
      if (r < 70) kind = KIND_COUNT;
      else if (r < 84) kind = KIND_READ;
      else if (r < 95) kind = KIND_SAMPLE;
      else kind = KIND_UNUSED;
      send_beat(kind, pick_ip(), 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [IP_W-1:0] base;
    rst_ni <= 1'b0;
    start <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= REG_RANGE_START;
    cfg_wdata_i <= '0;
    kind_i <= KIND_COUNT;
    ip_address_i <= '0;
    port_index_i <= 1'b0;
    queue_index_i <= '0;
    is_transmit_i <= 1'b0;
    settings_used = 0;
    drains = 0;
    foreach (beats_by_kind[k]) beats_by_kind[k] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The range is wider than the flow table so that the table edge can be crossed in range.
    base = 32'hC0A8_0000;
    configure(base, base + 32'd1199, 14'd16383, 4'd15, 4'd0);
    send_beat(KIND_COUNT, '0, 1'b0, 3'd0, 1'b0);
    send_beat(KIND_COUNT, base, 1'b0, 3'd0, 1'b0);
    send_beat(KIND_COUNT, base, 1'b1, 3'd7, 1'b1);
    send_beat(KIND_COUNT, base + FLOWS - 1, 1'b0, 3'd7, 1'b0);
    send_beat(KIND_COUNT, base + FLOWS, 1'b0, 3'd3, 1'b0);
    send_beat(KIND_COUNT, base - 1, 1'b0, 3'd1, 1'b0);
    send_beat(KIND_COUNT, base + 32'd1200, 1'b1, 3'd1, 1'b1);
    send_beat(KIND_COUNT, 32'hFFFF_FFFF, 1'b1, 3'd7, 1'b1);
    send_beat(KIND_READ, base, 1'b0, 3'd0, 1'b0);
    send_beat(KIND_READ, base + FLOWS - 1, 1'b0, 3'd7, 1'b0);
    send_beat(KIND_READ, base + FLOWS, 1'b0, 3'd3, 1'b0);
    send_beat(KIND_READ, 32'hFFFF_FFFF, 1'b1, 3'd7, 1'b1);
    send_beat(KIND_SAMPLE, '0, 1'b0, 3'd0, 1'b0);
    send_beat(KIND_SAMPLE, '0, 1'b0, 3'd0, 1'b0);
    send_beat(KIND_SAMPLE, '0, 1'b1, 3'd0, 1'b1);
    send_beat(KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, 3'd7, 1'b1);
    send_beat(KIND_COUNT, base, 1'b0, 3'd0, 1'b0);
    send_beat(KIND_SAMPLE, 32'hFFFF_FFFF, 1'b0, 3'd7, 1'b0);

    // An empty range: the start lies above the end.
    configure(32'h8000_0000, 32'h7FFF_FFFF, 14'd0, 4'd0, 4'd8);
    send_beat(KIND_COUNT, 32'h8000_0000, 1'b0, 3'd2, 1'b0);
    send_beat(KIND_READ, 32'h8000_0000, 1'b0, 3'd2, 1'b0);
    send_beat(KIND_SAMPLE, '0, 1'b1, 3'd0, 1'b1);
    send_beat(KIND_SAMPLE, '0, 1'b0, 3'd0, 1'b1);

    configure('0, 32'hFFFF_FFFF, 14'd0, 4'd8, 4'd15);
    run_random(600, 21);
    configure(32'hFFFF_FC00, 32'hFFFF_FFFF, 14'd16383, 4'd0, 4'd3);
    run_random(600, 86);
    configure_random();
    run_random(325, 0);
    configure_random();
    run_random(325, 0);

    drain();
    repeat (TAIL) @(posedge clk_i);
    $display("Covered %0d count, %0d sample, %0d read and %0d undefined-kind beats.",
             beats_by_kind[KIND_COUNT], beats_by_kind[KIND_SAMPLE], beats_by_kind[KIND_READ],
             beats_by_kind[KIND_UNUSED]);
    $display("Used %0d register settings and %0d full drains, sender idling at 21, 86 and 0%%.",
             settings_used, drains);
    if (mismatches == 0 && owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
